@@ design/tbb_pkg.sv @@
// ---------------------------------------------------------------------------
// tbb_pkg: shared definitions for the tint blend blit pixel unit
// Field widths, channel constants and configuration register indexes.
// ---------------------------------------------------------------------------
package tbb_pkg;

  // color channel width and full-scale value
  localparam int CH_BITS = 8;
  localparam logic [CH_BITS-1:0] CH_MAX = {CH_BITS{1'b1}};

  // coordinate and dimension widths
  localparam int COORD_BITS = 11;
  localparam int DIM_BITS   = 12;
  localparam int POS_BITS   = DIM_BITS + 2;
  localparam int MAX_DIM    = 2048;
  localparam logic [DIM_BITS-1:0] MAX_DIM_V = DIM_BITS'(MAX_DIM);

  // stream word widths, rounded up to whole bytes
  localparam int S_FIELDS_W = 2 * COORD_BITS + 4 * CH_BITS;
  localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
  localparam int M_FIELDS_W = 2 * COORD_BITS + 3 * CH_BITS;
  localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

  // configuration port
  localparam int CFG_DATA_W = 3 * CH_BITS;

  typedef enum logic [2:0] {
    CFG_TINT_COLOR    = 3'd0,
    CFG_TINT_AMOUNT   = 3'd1,
    CFG_DEST_X        = 3'd2,
    CFG_DEST_Y        = 3'd3,
    CFG_TARGET_WIDTH  = 3'd4,
    CFG_TARGET_HEIGHT = 3'd5,
    CFG_SOURCE_WIDTH  = 3'd6,
    CFG_FLIP          = 3'd7
  } cfg_reg_t;

endpackage

@@ design/tint_blend_blit_pixel_unit.sv @@
// ---------------------------------------------------------------------------
// tint_blend_blit_pixel_unit: per-pixel sprite blit with tint and alpha test
// Places each source pixel at the destination offset (optionally mirrored),
// clips it to the target, drops non-opaque pixels and blends toward a tint.
//
//   channel | dir | handshake          | content
//   s_*     | in  | s_tvalid/s_tready  | source pixel word and coordinates
//   m_*     | out | m_tvalid/m_tready  | placed, blended pixel; tuser = write
//   cfg_*   | in  | cfg_wen            | register index and write data
//
// One word is accepted per cycle while m_* is not stalled; an accepted word is
// taken into the input register and then moves into the result register, which
// drives m_tvalid. Placement, clipping and the three channel blends sit
// between those two registers. A stall on m_* holds both registers and backs
// up into s_tready. Reset (synchronous) empties both stages and loads the
// register defaults.
// ---------------------------------------------------------------------------
module tint_blend_blit_pixel_unit (
  input  logic                             clk,
  input  logic                             rst,
  // src_col[10:0], src_row[21:11], in_red[29:22], in_green[37:30],
  // in_blue[45:38], in_alpha[53:46], zero fill
  input  logic [tbb_pkg::S_TDATA_W-1:0]    s_tdata,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // out_col[10:0], out_row[21:11], out_red[29:22], out_green[37:30],
  // out_blue[45:38], zero fill
  output logic [tbb_pkg::M_TDATA_W-1:0]    m_tdata,
  // write_enable[0]
  output logic                             m_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  input  logic                             cfg_wen,
  input  tbb_pkg::cfg_reg_t                cfg_index,
  input  logic [tbb_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import tbb_pkg::*;

  // configuration registers
  logic [3*CH_BITS-1:0]  tint_color;
  logic [CH_BITS-1:0]    tint_amount;
  logic signed [DIM_BITS-1:0] dest_x;
  logic signed [DIM_BITS-1:0] dest_y;
  logic [DIM_BITS-1:0]   target_width;
  logic [DIM_BITS-1:0]   target_height;
  logic [DIM_BITS-1:0]   source_width;
  logic                  flip_horizontal;

  // input stage
  logic                  s1_valid;
  logic [COORD_BITS-1:0] s1_col;
  logic [COORD_BITS-1:0] s1_row;
  logic [CH_BITS-1:0]    s1_red;
  logic [CH_BITS-1:0]    s1_green;
  logic [CH_BITS-1:0]    s1_blue;
  logic [CH_BITS-1:0]    s1_alpha;

  // datapath between the stages
  logic                  out_load;
  logic signed [POS_BITS-1:0] pos_col;
  logic signed [POS_BITS-1:0] pos_row;
  logic [DIM_BITS-1:0]   tw_sat;
  logic [DIM_BITS-1:0]   th_sat;
  logic                  col_in;
  logic                  row_in;
  logic                  write_next;
  logic [CH_BITS-1:0]    red_blend;
  logic [CH_BITS-1:0]    green_blend;
  logic [CH_BITS-1:0]    blue_blend;
  logic [M_TDATA_W-1:0]  tdata_next;

  // write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tint_color      <= '0;
      tint_amount     <= '0;
      dest_x          <= '0;
      dest_y          <= '0;
      target_width    <= MAX_DIM_V;
      target_height   <= MAX_DIM_V;
      source_width    <= DIM_BITS'(1);
      flip_horizontal <= 1'b0;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        CFG_TINT_COLOR:    tint_color      <= cfg_wdata[3*CH_BITS-1:0];
        CFG_TINT_AMOUNT:   tint_amount     <= cfg_wdata[CH_BITS-1:0];
        CFG_DEST_X:        dest_x          <= cfg_wdata[DIM_BITS-1:0];
        CFG_DEST_Y:        dest_y          <= cfg_wdata[DIM_BITS-1:0];
        CFG_TARGET_WIDTH:  target_width    <= cfg_wdata[DIM_BITS-1:0];
        CFG_TARGET_HEIGHT: target_height   <= cfg_wdata[DIM_BITS-1:0];
        CFG_SOURCE_WIDTH:  source_width    <= cfg_wdata[DIM_BITS-1:0];
        CFG_FLIP:          flip_horizontal <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // advance when the result register is free or being drained
  assign out_load = !m_tvalid || m_tready;
  assign s_tready = !s1_valid || out_load;

  // capture input word
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      s1_col   <= s_tdata[COORD_BITS-1:0];
      s1_row   <= s_tdata[2*COORD_BITS-1:COORD_BITS];
      s1_red   <= s_tdata[2*COORD_BITS+CH_BITS-1:2*COORD_BITS];
      s1_green <= s_tdata[2*COORD_BITS+2*CH_BITS-1:2*COORD_BITS+CH_BITS];
      s1_blue  <= s_tdata[2*COORD_BITS+3*CH_BITS-1:2*COORD_BITS+2*CH_BITS];
      s1_alpha <= s_tdata[2*COORD_BITS+4*CH_BITS-1:2*COORD_BITS+3*CH_BITS];
    end
  end

  // place the pixel, mirroring the column when flip is set
  always_comb begin
    if (flip_horizontal) begin
      pos_col = POS_BITS'(dest_x) + $signed({2'b00, source_width})
              - POS_BITS'(1) - $signed({{(POS_BITS-COORD_BITS){1'b0}}, s1_col});
    end else begin
      pos_col = POS_BITS'(dest_x)
              + $signed({{(POS_BITS-COORD_BITS){1'b0}}, s1_col});
    end
    pos_row = POS_BITS'(dest_y)
            + $signed({{(POS_BITS-COORD_BITS){1'b0}}, s1_row});
  end

  // clip against the saturated target size
  assign tw_sat = (target_width  > MAX_DIM_V) ? MAX_DIM_V : target_width;
  assign th_sat = (target_height > MAX_DIM_V) ? MAX_DIM_V : target_height;
  assign col_in = !pos_col[POS_BITS-1] &&
                  (pos_col[POS_BITS-2:0] < {1'b0, tw_sat});
  assign row_in = !pos_row[POS_BITS-1] &&
                  (pos_row[POS_BITS-2:0] < {1'b0, th_sat});
  assign write_next = (s1_alpha == CH_MAX) && col_in && row_in;

  // blend each channel toward the tint
  tbb_blend u_blend_red (
    .pix     (s1_red),
    .tint    (tint_color[3*CH_BITS-1:2*CH_BITS]),
    .amt     (tint_amount),
    .blended (red_blend)
  );

  tbb_blend u_blend_green (
    .pix     (s1_green),
    .tint    (tint_color[2*CH_BITS-1:CH_BITS]),
    .amt     (tint_amount),
    .blended (green_blend)
  );

  tbb_blend u_blend_blue (
    .pix     (s1_blue),
    .tint    (tint_color[CH_BITS-1:0]),
    .amt     (tint_amount),
    .blended (blue_blend)
  );

  // pack the result word; a dropped pixel carries all zeros
  always_comb begin
    tdata_next = '0;
    if (write_next) begin
      tdata_next[M_FIELDS_W-1:0] = {blue_blend, green_blend, red_blend,
                                    pos_row[COORD_BITS-1:0],
                                    pos_col[COORD_BITS-1:0]};
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && s1_valid) begin
      m_tdata <= tdata_next;
      m_tuser <= write_next;
    end
  end

  // a dropped pixel never carries coordinates or color
  a_drop_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata == '0))
    else $error("dropped pixel with nonzero payload");

  // an accepted word always occupies the input stage next cycle
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> s1_valid)
    else $error("accepted word lost at input stage");

  // a stalled input stage keeps its word
  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !out_load) |=> s1_valid)
    else $error("input stage dropped a stalled word");

  // a word moved into the result register is presented next cycle
  a_result_shown: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_load) |=> m_tvalid)
    else $error("result register did not present a loaded word");

endmodule

@@ design/tbb_blend.sv @@
// ---------------------------------------------------------------------------
// tbb_blend: one color channel blended toward the tint
// out = (p*(MAX-amt) + t*amt + MAX/2) / MAX, rounded down, MAX = 2^CH_BITS-1.
// The division by MAX is a reciprocal estimate with a single correction.
// ---------------------------------------------------------------------------
module tbb_blend (
  input  logic [tbb_pkg::CH_BITS-1:0] pix,
  input  logic [tbb_pkg::CH_BITS-1:0] tint,
  input  logic [tbb_pkg::CH_BITS-1:0] amt,
  output logic [tbb_pkg::CH_BITS-1:0] blended
);
  import tbb_pkg::*;

  localparam int AW = 2 * CH_BITS + 1;

  logic [CH_BITS-1:0]   inv_amt;
  logic [2*CH_BITS-1:0] prod_pix;
  logic [2*CH_BITS-1:0] prod_tint;
  logic [AW-1:0]        acc;
  logic [AW-1:0]        quot_est;
  logic [AW-1:0]        rem;
  logic [AW-1:0]        quot;

  // weighted sum with rounding offset
  assign inv_amt   = CH_MAX - amt;
  assign prod_pix  = {{CH_BITS{1'b0}}, pix}  * {{CH_BITS{1'b0}}, inv_amt};
  assign prod_tint = {{CH_BITS{1'b0}}, tint} * {{CH_BITS{1'b0}}, amt};
  assign acc = {1'b0, prod_pix} + {1'b0, prod_tint} + AW'(CH_MAX >> 1);

  // estimate acc/MAX from below, then fix up by at most one
  assign quot_est = (acc + (acc >> CH_BITS)) >> CH_BITS;
  assign rem      = acc - ((quot_est << CH_BITS) - quot_est);
  assign quot     = (rem >= AW'(CH_MAX)) ? quot_est + AW'(1) : quot_est;
  assign blended  = quot[CH_BITS-1:0];

endmodule
